### design/plre_pkg.sv
// ----------------------------------------------------------------------------
// plre_pkg
// Shared types, register indexes and arithmetic helpers for the Plucker line
// reprojection error block.
// ----------------------------------------------------------------------------
package plre_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 63;
    localparam int ErrW     = 32;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_ROT_ROW0 = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_ROT_ROW1 = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_ROT_ROW2 = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_TRANS_X  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_TRANS_Y  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_TRANS_Z  = 3'd5;

    localparam logic [CfgDataW-1:0] ROT_ROW0_RST = 63'd524288;
    localparam logic [CfgDataW-1:0] ROT_ROW1_RST = 63'd1099511627776;
    localparam logic [CfgDataW-1:0] ROT_ROW2_RST = 63'd2305843009213693952;

    // Two result bits per stage in the root and quotient chains
    localparam int SqStages  = 16;
    localparam int DivStages = 16;

    typedef struct packed {
        logic signed [31:0] moment_x;
        logic signed [31:0] moment_y;
        logic signed [31:0] moment_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [23:0] obs_x1;
        logic signed [23:0] obs_y1;
        logic signed [23:0] obs_x2;
        logic signed [23:0] obs_y2;
    } t_in_word;

    typedef struct packed {
        logic [ErrW-1:0] reproj_error;
        logic            degenerate;
    } t_out_word;

    typedef struct packed {
        logic [63:0] op;
        logic [35:0] rem;
        logic [31:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [31:0] num_lo;
        logic [33:0] rem;
        logic [32:0] dvs;
        logic [31:0] quo;
    } t_div;

    function automatic logic signed [31:0] f_sat32(input logic signed [37:0] x);
        logic signed [31:0] y;
        if (x > 38'sd2147483647) begin
            y = 32'sh7FFFFFFF;
        end else if (x < -38'sd2147483648) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    function automatic t_sqrt f_sqrt_step(input t_sqrt x);
        t_sqrt       y;
        logic [35:0] trial;
        y = x;
        for (int k = 0; k < 2; k++) begin
            y.rem = {y.rem[33:0], y.op[63:62]};
            y.op  = {y.op[61:0], 2'b00};
            trial = {2'b00, y.root, 2'b01};
            if (y.rem >= trial) begin
                y.rem  = y.rem - trial;
                y.root = {y.root[30:0], 1'b1};
            end else begin
                y.root = {y.root[30:0], 1'b0};
            end
        end
        return y;
    endfunction

    function automatic t_div f_div_step(input t_div x);
        t_div y;
        y = x;
        for (int k = 0; k < 2; k++) begin
            y.rem    = {y.rem[32:0], y.num_lo[31]};
            y.num_lo = {y.num_lo[30:0], 1'b0};
            if (y.rem >= {1'b0, y.dvs}) begin
                y.rem = y.rem - {1'b0, y.dvs};
                y.quo = {y.quo[30:0], 1'b1};
            end else begin
                y.quo = {y.quo[30:0], 1'b0};
            end
        end
        return y;
    endfunction

endpackage

### design/plucker_line_reprojection_error.sv
// ----------------------------------------------------------------------------
// plucker_line_reprojection_error
// Camera-frame moment of a world Plucker line and its mean point-to-line
// distance to two observed endpoints, fully pipelined fixed point.
// ----------------------------------------------------------------------------
// A new word is taken in every cycle at which start is high; busy is never
// raised. Each word gives exactly one result. The result is driven on the
// ports, with o_strobe high for one cycle, from the output register after the
// divider chain. The integer square root (two root bits per stage) and the
// divider (two quotient bits per stage) follow eight arithmetic stages.
// Results cannot be held off. Pose registers may be written only while no
// word is in flight.
module plucker_line_reprojection_error (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  plre_pkg::t_in_word                  i_in,
    output logic                                o_strobe,
    output plre_pkg::t_out_word                 o_out,
    input  logic                                i_cfg_we,
    input  logic [plre_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  logic [plre_pkg::CfgDataW-1:0]       i_cfg_data
);
    import plre_pkg::*;

    // pose registers
    logic [CfgDataW-1:0] r_rot [3];
    logic signed [31:0]  r_trans [3];

    // valid chain
    logic                r_v [8];
    logic                r_sqv [SqStages+1];
    logic                r_dvv [DivStages+1];

    // stage 1: rotation products
    logic signed [52:0]  r_pn [3][3];
    logic signed [52:0]  r_pv [3][3];
    logic signed [52:0]  r_pt [3][3];
    logic signed [23:0]  r_obs1 [4];
    // stage 2
    logic signed [36:0]  r_a [3];
    logic signed [31:0]  r_w [3];
    logic signed [31:0]  r_tc [3];
    logic signed [23:0]  r_obs2 [4];
    // stage 3
    logic signed [36:0]  r_a3 [3];
    logic signed [63:0]  r_c [6];
    logic signed [23:0]  r_obs3 [4];
    // stage 4
    logic signed [49:0]  r_nc [3];
    logic                r_dg4;
    logic signed [23:0]  r_obs4 [4];
    // stage 5
    logic signed [49:0]  r_nc5 [3];
    logic [4:0]          r_sh;
    logic                r_dg5;
    logic signed [23:0]  r_obs5 [4];
    // stage 6
    logic signed [31:0]  r_sc [3];
    logic                r_dg6;
    logic signed [23:0]  r_obs6 [4];
    // stage 7
    logic signed [55:0]  r_pd [4];
    logic signed [47:0]  r_z16;
    logic signed [63:0]  r_sq0;
    logic signed [63:0]  r_sq1;
    logic                r_dg7;
    // stage 8
    logic [59:0]         r_sum;
    logic [63:0]         r_q;
    logic                r_dg8;
    // root and quotient chains
    t_sqrt               r_sq [SqStages+1];
    logic [59:0]         r_sqsum [SqStages+1];
    logic                r_sqdg [SqStages+1];
    t_div                r_dv [DivStages+1];
    logic                r_dvsat [DivStages+1];
    logic                r_dvdg [DivStages+1];

    logic                n_strobe;
    logic signed [36:0]  n_a [3];
    logic signed [31:0]  n_w [3];
    logic signed [31:0]  n_tc [3];
    logic signed [49:0]  n_nc [3];
    logic [4:0]          n_sh;
    logic [59:0]         n_sum;
    logic [63:0]         n_q;
    logic [32:0]         n_dvs;

    assign busy = 1'b0;

    // ---------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0]   <= ROT_ROW0_RST;
            r_rot[1]   <= ROT_ROW1_RST;
            r_rot[2]   <= ROT_ROW2_RST;
            r_trans[0] <= '0;
            r_trans[1] <= '0;
            r_trans[2] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROT_ROW0: r_rot[0]   <= i_cfg_data;
                CFG_ROT_ROW1: r_rot[1]   <= i_cfg_data;
                CFG_ROT_ROW2: r_rot[2]   <= i_cfg_data;
                CFG_TRANS_X:  r_trans[0] <= i_cfg_data[31:0];
                CFG_TRANS_Y:  r_trans[1] <= i_cfg_data[31:0];
                CFG_TRANS_Z:  r_trans[2] <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // ---------------- valid chain
    assign n_strobe = r_dvv[DivStages];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) r_v[k] <= 1'b0;
            for (int k = 0; k <= SqStages; k++) r_sqv[k] <= 1'b0;
            for (int k = 0; k <= DivStages; k++) r_dvv[k] <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_v[0] <= start;
            for (int k = 1; k < 8; k++) r_v[k] <= r_v[k-1];
            r_sqv[0] <= r_v[7];
            for (int k = 1; k <= SqStages; k++) r_sqv[k] <= r_sqv[k-1];
            r_dvv[0] <= r_sqv[SqStages];
            for (int k = 1; k <= DivStages; k++) r_dvv[k] <= r_dvv[k-1];
            o_strobe <= n_strobe;
        end
    end

    // ---------------- arithmetic
    always_comb begin
        logic signed [54:0] sn, sv, st;
        logic signed [55:0] rn, rv, rt;
        logic signed [37:0] av, at;
        for (int i = 0; i < 3; i++) begin
            sn = 55'(r_pn[0][i]) + 55'(r_pn[1][i]) + 55'(r_pn[2][i]);
            sv = 55'(r_pv[0][i]) + 55'(r_pv[1][i]) + 55'(r_pv[2][i]);
            st = 55'(r_pt[0][i]) + 55'(r_pt[1][i]) + 55'(r_pt[2][i]);
            rn = 56'(sn) + 56'sd262144;
            rv = 56'(sv) + 56'sd262144;
            rt = 56'(st) + 56'sd262144;
            n_a[i] = rn[55:19];
            av     = 38'(signed'(rv[55:19]));
            at     = -38'(signed'(rt[55:19]));
            n_w[i]  = f_sat32(av);
            n_tc[i] = f_sat32(at);
        end
    end

    always_comb begin
        logic signed [64:0] df;
        logic signed [48:0] xr;
        for (int i = 0; i < 3; i++) begin
            df = 65'(r_c[2*i]) - 65'(r_c[2*i+1]) + 65'sd32768;
            xr = df[64:16];
            n_nc[i] = 50'(r_a3[i]) + 50'(xr);
        end
    end

    // smallest common shift that brings all components into 32 bits
    always_comb begin
        logic signed [49:0] tmp;
        logic               fit;
        n_sh = 5'd18;
        for (int s = 18; s >= 0; s--) begin
            fit = 1'b1;
            for (int i = 0; i < 3; i++) begin
                tmp = r_nc[i] >>> (31 + s);
                if (!(tmp == 50'sd0 || tmp == -50'sd1)) fit = 1'b0;
            end
            if (fit) n_sh = 5'(s);
        end
    end

    always_comb begin
        logic signed [57:0] d1, d2;
        logic [57:0]        m1, m2;
        d1 = 58'(r_pd[0]) + 58'(r_pd[1]) + 58'(r_z16);
        d2 = 58'(r_pd[2]) + 58'(r_pd[3]) + 58'(r_z16);
        m1 = d1[57] ? 58'(-d1) : 58'(d1);
        m2 = d2[57] ? 58'(-d2) : 58'(d2);
        n_sum = 60'(m1) + 60'(m2);
        n_q   = 64'(r_sq0) + 64'(r_sq1);
    end

    assign n_dvs = {r_sq[SqStages].root, 1'b0};

    always_ff @(posedge i_clk) begin
        // stage 1
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                r_pn[j][i] <= 53'(signed'(r_rot[j][21*i +: 21])) * 53'(
                    j == 0 ? i_in.moment_x : (j == 1 ? i_in.moment_y : i_in.moment_z));
                r_pv[j][i] <= 53'(signed'(r_rot[j][21*i +: 21])) * 53'(
                    j == 0 ? i_in.dir_x : (j == 1 ? i_in.dir_y : i_in.dir_z));
                r_pt[j][i] <= 53'(signed'(r_rot[j][21*i +: 21])) * 53'(r_trans[j]);
            end
        end
        r_obs1[0] <= i_in.obs_x1;
        r_obs1[1] <= i_in.obs_y1;
        r_obs1[2] <= i_in.obs_x2;
        r_obs1[3] <= i_in.obs_y2;
        // stage 2
        r_a    <= n_a;
        r_w    <= n_w;
        r_tc   <= n_tc;
        r_obs2 <= r_obs1;
        // stage 3: cross product terms
        r_a3   <= r_a;
        r_c[0] <= 64'(r_tc[1]) * 64'(r_w[2]);
        r_c[1] <= 64'(r_tc[2]) * 64'(r_w[1]);
        r_c[2] <= 64'(r_tc[2]) * 64'(r_w[0]);
        r_c[3] <= 64'(r_tc[0]) * 64'(r_w[2]);
        r_c[4] <= 64'(r_tc[0]) * 64'(r_w[1]);
        r_c[5] <= 64'(r_tc[1]) * 64'(r_w[0]);
        r_obs3 <= r_obs2;
        // stage 4
        r_nc   <= n_nc;
        r_dg4  <= (n_nc[0] == 50'sd0) && (n_nc[1] == 50'sd0);
        r_obs4 <= r_obs3;
        // stage 5
        r_nc5  <= r_nc;
        r_sh   <= n_sh;
        r_dg5  <= r_dg4;
        r_obs5 <= r_obs4;
        // stage 6
        for (int i = 0; i < 3; i++) begin
            r_sc[i] <= 32'(r_nc5[i] >>> r_sh);
        end
        r_dg6  <= r_dg5;
        r_obs6 <= r_obs5;
        // stage 7
        r_pd[0] <= 56'(r_sc[0]) * 56'(r_obs6[0]);
        r_pd[1] <= 56'(r_sc[1]) * 56'(r_obs6[1]);
        r_pd[2] <= 56'(r_sc[0]) * 56'(r_obs6[2]);
        r_pd[3] <= 56'(r_sc[1]) * 56'(r_obs6[3]);
        r_z16   <= 48'(r_sc[2]) <<< 16;
        r_sq0   <= 64'(r_sc[0]) * 64'(r_sc[0]);
        r_sq1   <= 64'(r_sc[1]) * 64'(r_sc[1]);
        r_dg7   <= r_dg6;
        // stage 8
        r_sum <= n_sum;
        r_q   <= n_q;
        r_dg8 <= r_dg7;
        // square root chain
        r_sq[0]    <= '{op: r_q, rem: '0, root: '0};
        r_sqsum[0] <= r_sum;
        r_sqdg[0]  <= r_dg8;
        for (int k = 1; k <= SqStages; k++) begin
            r_sq[k]    <= f_sqrt_step(r_sq[k-1]);
            r_sqsum[k] <= r_sqsum[k-1];
            r_sqdg[k]  <= r_sqdg[k-1];
        end
        // divider chain; saturates when the quotient needs more than 32 bits
        r_dv[0]    <= '{num_lo: r_sqsum[SqStages][31:0],
                        rem: 34'(r_sqsum[SqStages][59:32]),
                        dvs: n_dvs, quo: '0};
        r_dvsat[0] <= 33'(r_sqsum[SqStages][59:32]) >= n_dvs;
        r_dvdg[0]  <= r_sqdg[SqStages];
        for (int k = 1; k <= DivStages; k++) begin
            r_dv[k]    <= f_div_step(r_dv[k-1]);
            r_dvsat[k] <= r_dvsat[k-1];
            r_dvdg[k]  <= r_dvdg[k-1];
        end
        // output word
        o_out.reproj_error <= r_dvsat[DivStages] ? '1 : r_dv[DivStages].quo;
        o_out.degenerate   <= r_dvdg[DivStages];
    end

    // ---------------- assertions
    a_strobe_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, 43))
        else $error("result word without a matching start");

    a_degen_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.degenerate) |-> (o_out.reproj_error == '1))
        else $error("degenerate line without saturated error");

    a_zero_root_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sqv[SqStages] && r_sq[SqStages].root == '0) |=> r_dvsat[0])
        else $error("zero norm did not saturate");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for plucker_line_reprojection_error: several pose
// settings, directed corner lines then random lines with random idle gaps,
// each result compared against a bit-exact line distance predictor.
// ----------------------------------------------------------------------------
module tb;
    import plre_pkg::*;

    class line_dist_board;
        logic [62:0]        rot [3];
        logic signed [31:0] trans [3];
        t_out_word          pending [$];
        int                 n_bad;

        function new();
            rot[0] = ROT_ROW0_RST;
            rot[1] = ROT_ROW1_RST;
            rot[2] = ROT_ROW2_RST;
            trans[0] = 0;
            trans[1] = 0;
            trans[2] = 0;
            n_bad = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                CFG_ROT_ROW0: rot[0] = data;
                CFG_ROT_ROW1: rot[1] = data;
                CFG_ROT_ROW2: rot[2] = data;
                CFG_TRANS_X:  trans[0] = data[31:0];
                CFG_TRANS_Y:  trans[1] = data[31:0];
                CFG_TRANS_Z:  trans[2] = data[31:0];
                default: ;
            endcase
        endfunction

        function logic signed [79:0] round_q(logic signed [79:0] x, int k);
            return (x + (80'sd1 <<< (k - 1))) >>> k;
        endfunction

        function logic signed [79:0] clamp32(logic signed [79:0] x);
            if (x > 80'sd2147483647) return 80'sd2147483647;
            if (x < -80'sd2147483648) return -80'sd2147483648;
            return x;
        endfunction

        function logic [79:0] floor_root(logic [79:0] q);
            logic [79:0] res, trial;
            res = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = res | (80'd1 << b);
                if (trial * trial <= q) res = trial;
            end
            return res;
        endfunction

        function t_out_word distance(t_in_word w);
            logic signed [79:0] rm [3][3];
            logic signed [79:0] mo [3], dv [3], rn [3], rv [3], tc [3], nc [3], sc [3];
            logic signed [79:0] sn, sv, st, d1, d2;
            logic signed [20:0] e;
            logic [79:0]        sum, q, r, err;
            t_out_word          o;
            bit                 fits;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    e = rot[i][21*j +: 21];
                    rm[i][j] = e;
                end
            end
            mo[0] = w.moment_x; mo[1] = w.moment_y; mo[2] = w.moment_z;
            dv[0] = w.dir_x;    dv[1] = w.dir_y;    dv[2] = w.dir_z;
            for (int i = 0; i < 3; i++) begin
                sn = 0; sv = 0; st = 0;
                for (int j = 0; j < 3; j++) begin
                    sn += rm[j][i] * mo[j];
                    sv += rm[j][i] * dv[j];
                    st += rm[j][i] * 80'(signed'(trans[j]));
                end
                rn[i] = round_q(sn, 19);
                rv[i] = clamp32(round_q(sv, 19));
                tc[i] = clamp32(-round_q(st, 19));
            end
            nc[0] = rn[0] + round_q(tc[1] * rv[2] - tc[2] * rv[1], 16);
            nc[1] = rn[1] + round_q(tc[2] * rv[0] - tc[0] * rv[2], 16);
            nc[2] = rn[2] + round_q(tc[0] * rv[1] - tc[1] * rv[0], 16);
            o.degenerate = (nc[0] == 0 && nc[1] == 0);
            for (int s = 0; s < 40; s++) begin
                fits = 1;
                for (int i = 0; i < 3; i++) begin
                    sc[i] = nc[i] >>> s;
                    if (sc[i] != clamp32(sc[i])) fits = 0;
                end
                if (fits) break;
            end
            if (o.degenerate) begin
                o.reproj_error = '1;
            end else begin
                d1 = sc[0] * 80'(w.obs_x1) + sc[1] * 80'(w.obs_y1) + sc[2] * 80'sd65536;
                d2 = sc[0] * 80'(w.obs_x2) + sc[1] * 80'(w.obs_y2) + sc[2] * 80'sd65536;
                sum = (d1 < 0 ? -d1 : d1) + (d2 < 0 ? -d2 : d2);
                q = sc[0] * sc[0] + sc[1] * sc[1];
                r = floor_root(q);
                if (r == 0) begin
                    o.reproj_error = '1;
                end else begin
                    err = sum / (2 * r);
                    o.reproj_error = (err > 80'hFFFFFFFF) ? 32'hFFFFFFFF : err[31:0];
                end
            end
            return o;
        endfunction

        function void note(t_in_word w);
            pending.push_back(distance(w));
        endfunction

        function void check(t_out_word got);
            t_out_word exp_w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word err=%h degen=%b", $time,
                         got.reproj_error, got.degenerate);
                n_bad++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.reproj_error !== exp_w.reproj_error) begin
                $display("%0t: reproj_error expected %h actual %h", $time,
                         exp_w.reproj_error, got.reproj_error);
                n_bad++;
            end
            if (got.degenerate !== exp_w.degenerate) begin
                $display("%0t: degenerate expected %b actual %b", $time,
                         exp_w.degenerate, got.degenerate);
                n_bad++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in_word             i_in;
    logic                 o_strobe;
    t_out_word            o_out;
    logic                 i_cfg_we;
    logic [CfgIdxW-1:0]   i_cfg_idx;
    logic [CfgDataW-1:0]  i_cfg_data;

    line_dist_board board;
    int                   idle_cycles;
    bit                   no_gaps;

    plucker_line_reprojection_error i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_strobe   (o_strobe),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        bit act;
        act = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                board.note(i_in);
                act = 1'b1;
            end
            if (o_strobe) begin
                board.check(o_out);
                act = 1'b1;
            end
            if (i_cfg_we) act = 1'b1;
            idle_cycles <= act ? 0 : idle_cycles + 1;
            if (idle_cycles > 5000) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (no_gaps || p < 60) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    task automatic set_pose(logic [62:0] r0, logic [62:0] r1, logic [62:0] r2,
                            logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        cfg_write(CFG_ROT_ROW0, r0);
        cfg_write(CFG_ROT_ROW1, r1);
        cfg_write(CFG_ROT_ROW2, r2);
        cfg_write(CFG_TRANS_X, {31'd0, tx});
        cfg_write(CFG_TRANS_Y, {31'd0, ty});
        cfg_write(CFG_TRANS_Z, {31'd0, tz});
        // unmapped indexes must leave the pose alone
        cfg_write(3'd6, 63'({$urandom, $urandom}));
        cfg_write(3'd7, 63'({$urandom, $urandom}));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send(t_in_word w);
        int g;
        start <= 1'b1;
        i_in  <= w;
        do @(posedge i_clk); while (busy);
        g = gap_len();
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand32();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            1, 2: return $signed($urandom_range(2 << 16, 0)) - (1 << 16);
            3: return 0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] rand24();
        case ($urandom_range(4))
            0: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
            1, 2: return 24'($urandom_range(4 << 16, 0) - (2 << 16));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_in_word rand_line();
        t_in_word w;
        w.moment_x = rand32(); w.moment_y = rand32(); w.moment_z = rand32();
        w.dir_x    = rand32(); w.dir_y    = rand32(); w.dir_z    = rand32();
        w.obs_x1   = rand24(); w.obs_y1   = rand24();
        w.obs_x2   = rand24(); w.obs_y2   = rand24();
        return w;
    endfunction

    function automatic t_in_word mk(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                                    logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                    logic [23:0] x1, logic [23:0] y1,
                                    logic [23:0] x2, logic [23:0] y2);
        t_in_word w;
        w = {nx, ny, nz, vx, vy, vz, x1, y1, x2, y2};
        return w;
    endfunction

    function automatic logic [62:0] rand_row();
        logic [20:0] e [3];
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(3))
                0: e[k] = $urandom_range(1) ? 21'h0FFFFF : 21'h100000;
                1: e[k] = 0;
                default: e[k] = 21'($urandom);
            endcase
        end
        return {e[2], e[1], e[0]};
    endfunction

    localparam logic [62:0] ROW_MAX = {3{21'h0FFFFF}};
    localparam logic [62:0] ROW_MIN = {3{21'h100000}};

    initial begin
        board      = new();
        idle_cycles = 0;
        no_gaps    = 0;
        i_rst_n    = 0;
        start      = 0;
        i_in       = '0;
        i_cfg_we   = 0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset pose: identity, zero translation
        send(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(0, 0, 32'h10000, 32'h10000, 0, 0, 24'h10000, 0, 0, 0));
        send(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(32'h10000, 32'h10000, 32'h10000, 0, 0, 0,
                24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000));
        send(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
        send(mk(32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h80000000,
                24'h800000, 24'h800000, 24'h800000, 24'h800000));
        send(mk(1, 0, 32'h7FFFFFFF, 0, 0, 0, 24'h800000, 0, 24'h7FFFFF, 0));
        send(mk(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 0, 0, 0,
                24'hFFFFFF, 24'hFFFFFF, 1, 1));

        // large translation: cross term forces scaling, tiny normal after it
        set_pose(ROT_ROW0_RST, ROT_ROW1_RST, ROT_ROW2_RST, 32'h7FFFFFFF, 0, 0);
        send(mk(1, 0, 0, 0, 32'h7FFFFFFF, 0, 24'h10000, 0, 0, 0));
        send(mk(0, 0, 0, 0, 32'h7FFFFFFF, 0, 24'h10000, 0, 0, 0));
        send(mk(0, 32'h40000000, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 2, 3, 4));
        send(mk(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0));
        set_pose(ROT_ROW0_RST, ROT_ROW1_RST, ROT_ROW2_RST,
                 32'h80000000, 32'h80000000, 32'h80000000);
        send(mk(32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF));
        send(mk(0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0));
        set_pose(ROW_MAX, ROW_MIN, ROW_MAX, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send(mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000));
        for (int k = 0; k < 6; k++) send(rand_line());
        set_pose(ROW_MIN, ROW_MIN, ROW_MIN, 0, 0, 0);
        for (int k = 0; k < 6; k++) send(rand_line());

        for (int ph = 0; ph < 10; ph++) begin
            if (ph % 3 == 0) begin
                set_pose(ROT_ROW0_RST, ROT_ROW1_RST, ROT_ROW2_RST,
                         rand32(), rand32(), rand32());
            end else begin
                set_pose(rand_row(), rand_row(), rand_row(), rand32(), rand32(), rand32());
            end
            no_gaps = (ph % 4 == 1);
            for (int k = 0; k < 70; k++) send(rand_line());
        end
        start <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (board.n_bad == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
